[rtl/actb_pkg.sv]
// Shared types and codes for the Aho-Corasick trie builder.
// No dependencies; the interfaces and the trie builder refer to it by scoped names.
`default_nettype none
package actb_pkg;

   localparam int OP_W     = 3;
   localparam int SYMBOL_W = 5;
   localparam int FIELD_W  = 10;
   localparam int STATUS_W = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [SYMBOL_W-1:0] symbol_type;
   typedef logic [FIELD_W-1:0]  field_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_LETTER = 3'd0;
   localparam op_type OP_END    = 3'd1;
   localparam op_type OP_BUILD  = 3'd2;
   localparam op_type OP_QUERY  = 3'd3;
   localparam op_type OP_CLEAR  = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   typedef enum logic [19:0] {
      S_IDLE   = 20'h00001,
      S_CLR    = 20'h00002,
      S_LRD    = 20'h00004,
      S_LCHK   = 20'h00008,
      S_QRD    = 20'h00010,
      S_QOUT   = 20'h00020,
      S_FIN    = 20'h00040,
      B_RI     = 20'h00080,
      B_CI     = 20'h00100,
      B_HD     = 20'h00200,
      B_CUR    = 20'h00400,
      B_SON    = 20'h00800,
      B_SONCK  = 20'h01000,
      B_F0     = 20'h02000,
      B_WCHK   = 20'h04000,
      B_WRD    = 20'h08000,
      B_WF     = 20'h10000,
      B_FSON   = 20'h20000,
      B_WR     = 20'h40000,
      B_NXT    = 20'h80000
   } state_type;

endpackage
`default_nettype wire

[rtl/actb_req_if.sv]
// Request channel of the trie builder: valid/ready plus op, symbol and node index.
// Depends on actb_pkg.
`default_nettype none
interface actb_req_if;
   logic                   valid;
   logic                   ready;
   actb_pkg::op_type       op;
   actb_pkg::symbol_type   symbol;
   actb_pkg::field_type    node_index;

   modport source (output valid, output op, output symbol, output node_index, input ready);
   modport sink   (input valid, input op, input symbol, input node_index, output ready);
endinterface
`default_nettype wire

[rtl/actb_rsp_if.sv]
// Response channel of the trie builder: valid/ready plus node, links and status.
// Depends on actb_pkg.
`default_nettype none
interface actb_rsp_if;
   logic                   valid;
   logic                   ready;
   actb_pkg::field_type    result_node;
   actb_pkg::field_type    fail_link;
   actb_pkg::field_type    parent_node;
   actb_pkg::status_type   status;

   modport source (output valid, output result_node, output fail_link, output parent_node,
                   output status, input ready);
   modport sink   (input valid, input result_node, input fail_link, input parent_node,
                   input status, output ready);
endinterface
`default_nettype wire

[rtl/actb_ram.sv]
// Simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
`default_nettype none
module actb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[rtl/aho_corasick_trie_builder.sv]
// Aho-Corasick trie builder: insert sequencer, breadth-first link builder, query.
// Depends on actb_pkg, actb_req_if, actb_rsp_if and actb_ram.
//
//   channel   dir   handshake         payload
//   req_ch    in    valid/ready       op, symbol, node_index
//   rsp_ch    out   valid/ready       result_node, fail_link, parent_node, status
//
// One request at a time; ready only while the sequencer idles. A result waits in an
// output register, so the next request is taken while it is still pending; a full one
// holds the sequencer in its last state. A letter that creates a node clears the new
// node's row; a clear sweeps the root row. A build first queues the root's children,
// then reads each queued node's children and follows failure links for each child.
// After reset the root row is swept before the first request is taken.
`default_nettype none
module aho_corasick_trie_builder #(
   parameter int MAX_NODES = 1024,
   parameter int ALPHABET  = 26
) (
   input  wire logic   clock,
   input  wire logic   reset,
   actb_req_if.sink    req_ch,
   actb_rsp_if.source  rsp_ch
);
   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int SYM_W   = $clog2(ALPHABET);
   localparam int CNT_W   = NODE_W + 1;
   localparam int CDEPTH  = MAX_NODES * (2 ** SYM_W);
   localparam int CADDR_W = NODE_W + SYM_W;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [SYM_W-1:0]   sym_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [CADDR_W-1:0] caddr_type;

   actb_pkg::state_type  state_ff, state_in;
   actb_pkg::op_type     op_ff, op_in;
   sym_type              sym_ff, sym_in;
   node_type             idx_ff, idx_in;
   cnt_type              nc_ff, nc_in;
   node_type             cursor_ff, cursor_in;
   node_type             row_ff, row_in;
   sym_type              k_ff, k_in;
   logic                 ret_idle_ff, ret_idle_in;
   sym_type              i_ff, i_in;
   cnt_type              head_ff, head_in;
   cnt_type              tail_ff, tail_in;
   node_type             cur_ff, cur_in;
   node_type             son_ff, son_in;
   node_type             f_ff, f_in;
   cnt_type              guard_ff, guard_in;
   actb_pkg::field_type  res_ff, res_in;
   actb_pkg::field_type  fl_ff, fl_in;
   actb_pkg::field_type  par_ff, par_in;
   actb_pkg::status_type st_ff, st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   actb_pkg::field_type  o_res_ff, o_res_in;
   actb_pkg::field_type  o_fl_ff, o_fl_in;
   actb_pkg::field_type  o_par_ff, o_par_in;
   actb_pkg::status_type o_st_ff, o_st_in;

   logic      child_we, fail_we, parent_we, queue_we;
   caddr_type child_waddr, child_raddr;
   node_type  child_wdata, child_rdata;
   node_type  fail_waddr, fail_raddr, fail_wdata, fail_rdata;
   node_type  parent_waddr, parent_raddr, parent_wdata, parent_rdata;
   node_type  queue_waddr, queue_raddr, queue_wdata, queue_rdata;
   node_type  fsel;
   logic      last_i, last_k;

   actb_ram #(.DEPTH(CDEPTH), .WIDTH(NODE_W)) u_child (
      .clock(clock), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
      .raddr(child_raddr), .rdata(child_rdata));
   actb_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
      .clock(clock), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
      .raddr(fail_raddr), .rdata(fail_rdata));
   actb_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_parent (
      .clock(clock), .we(parent_we), .waddr(parent_waddr), .wdata(parent_wdata),
      .raddr(parent_raddr), .rdata(parent_rdata));
   actb_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
      .clock(clock), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
      .raddr(queue_raddr), .rdata(queue_rdata));

   assign req_ch.ready       = (state_ff == actb_pkg::S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_node = o_res_ff;
   assign rsp_ch.fail_link   = o_fl_ff;
   assign rsp_ch.parent_node = o_par_ff;
   assign rsp_ch.status      = o_st_ff;

   assign last_i = (32'(i_ff) == 32'(ALPHABET - 1));
   assign last_k = (32'(k_ff) == 32'(ALPHABET - 1));
   assign fsel   = (cnt_type'(f_ff) >= nc_ff) ? '0 : f_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sym_in       = sym_ff;
      idx_in       = idx_ff;
      nc_in        = nc_ff;
      cursor_in    = cursor_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      ret_idle_in  = ret_idle_ff;
      i_in         = i_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      son_in       = son_ff;
      f_in         = f_ff;
      guard_in     = guard_ff;
      res_in       = res_ff;
      fl_in        = fl_ff;
      par_in       = par_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_res_in     = o_res_ff;
      o_fl_in      = o_fl_ff;
      o_par_in     = o_par_ff;
      o_st_in      = o_st_ff;

      child_we     = 1'b0;
      child_waddr  = {row_ff, k_ff};
      child_wdata  = '0;
      child_raddr  = {cursor_ff, sym_ff};
      fail_we      = 1'b0;
      fail_waddr   = row_ff;
      fail_wdata   = '0;
      fail_raddr   = idx_ff;
      parent_we    = 1'b0;
      parent_waddr = row_ff;
      parent_wdata = '0;
      parent_raddr = idx_ff;
      queue_we     = 1'b0;
      queue_waddr  = tail_ff[NODE_W-1:0];
      queue_wdata  = son_ff;
      queue_raddr  = head_ff[NODE_W-1:0];

      case (state_ff)
         actb_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               op_in  = req_ch.op;
               sym_in = sym_type'(32'(req_ch.symbol));
               idx_in = node_type'(32'(req_ch.node_index));
               res_in = '0;
               fl_in  = '0;
               par_in = '0;
               st_in  = actb_pkg::ST_OK;
               case (req_ch.op)
                  actb_pkg::OP_LETTER: begin
                     if (32'(req_ch.symbol) >= 32'(ALPHABET)) begin
                        res_in   = actb_pkg::field_type'(cursor_ff);
                        st_in    = actb_pkg::ST_RANGE;
                        state_in = actb_pkg::S_FIN;
                     end else begin
                        state_in = actb_pkg::S_LRD;
                     end
                  end
                  actb_pkg::OP_END: begin
                     res_in    = actb_pkg::field_type'(cursor_ff);
                     cursor_in = '0;
                     state_in  = actb_pkg::S_FIN;
                  end
                  actb_pkg::OP_BUILD: begin
                     i_in     = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = actb_pkg::B_RI;
                  end
                  actb_pkg::OP_QUERY: begin
                     if (32'(req_ch.node_index) < 32'(nc_ff)) begin
                        state_in = actb_pkg::S_QRD;
                     end else begin
                        st_in    = actb_pkg::ST_RANGE;
                        state_in = actb_pkg::S_FIN;
                     end
                  end
                  actb_pkg::OP_CLEAR: begin
                     nc_in       = cnt_type'(1);
                     cursor_in   = '0;
                     row_in      = '0;
                     k_in        = '0;
                     ret_idle_in = 1'b0;
                     state_in    = actb_pkg::S_CLR;
                  end
                  default: begin
                     state_in = actb_pkg::S_FIN;
                  end
               endcase
            end
         end
         actb_pkg::S_LRD: begin
            state_in = actb_pkg::S_LCHK;
         end
         actb_pkg::S_LCHK: begin
            if (child_rdata != '0) begin
               cursor_in = child_rdata;
               res_in    = actb_pkg::field_type'(child_rdata);
               state_in  = actb_pkg::S_FIN;
            end else if (32'(nc_ff) < 32'(MAX_NODES)) begin
               child_we    = 1'b1;
               child_waddr = {cursor_ff, sym_ff};
               child_wdata = node_type'(nc_ff);
               nc_in       = nc_ff + cnt_type'(1);
               cursor_in   = node_type'(nc_ff);
               res_in      = actb_pkg::field_type'(nc_ff);
               row_in      = node_type'(nc_ff);
               k_in        = '0;
               ret_idle_in = 1'b0;
               state_in    = actb_pkg::S_CLR;
            end else begin
               res_in   = actb_pkg::field_type'(cursor_ff);
               st_in    = actb_pkg::ST_FULL;
               state_in = actb_pkg::S_FIN;
            end
         end
         actb_pkg::S_CLR: begin
            child_we  = 1'b1;
            fail_we   = (k_ff == '0);
            parent_we = (k_ff == '0);
            k_in      = k_ff + sym_type'(1);
            if (last_k) begin
               state_in = ret_idle_ff ? actb_pkg::S_IDLE : actb_pkg::S_FIN;
            end
         end
         actb_pkg::S_QRD: begin
            state_in = actb_pkg::S_QOUT;
         end
         actb_pkg::S_QOUT: begin
            res_in   = actb_pkg::field_type'(idx_ff);
            fl_in    = actb_pkg::field_type'(fail_rdata);
            par_in   = actb_pkg::field_type'(parent_rdata);
            state_in = actb_pkg::S_FIN;
         end
         actb_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               o_res_in     = res_ff;
               o_fl_in      = fl_ff;
               o_par_in     = par_ff;
               o_st_in      = st_ff;
               state_in     = actb_pkg::S_IDLE;
            end
         end
         actb_pkg::B_RI: begin
            child_raddr = {node_type'(0), i_ff};
            state_in    = actb_pkg::B_CI;
         end
         actb_pkg::B_CI: begin
            if (child_rdata != '0 && 32'(tail_ff) < 32'(MAX_NODES)) begin
               fail_we      = 1'b1;
               fail_waddr   = child_rdata;
               parent_we    = 1'b1;
               parent_waddr = child_rdata;
               queue_we     = 1'b1;
               queue_wdata  = child_rdata;
               tail_in      = tail_ff + cnt_type'(1);
            end
            if (last_i) begin
               state_in = actb_pkg::B_HD;
            end else begin
               i_in     = i_ff + sym_type'(1);
               state_in = actb_pkg::B_RI;
            end
         end
         actb_pkg::B_HD: begin
            if (head_ff < tail_ff) begin
               head_in  = head_ff + cnt_type'(1);
               state_in = actb_pkg::B_CUR;
            end else begin
               state_in = actb_pkg::S_FIN;
            end
         end
         actb_pkg::B_CUR: begin
            cur_in   = queue_rdata;
            i_in     = '0;
            state_in = actb_pkg::B_SON;
         end
         actb_pkg::B_SON: begin
            child_raddr = {cur_ff, i_ff};
            state_in    = actb_pkg::B_SONCK;
         end
         actb_pkg::B_SONCK: begin
            son_in     = child_rdata;
            fail_raddr = cur_ff;
            if (child_rdata == '0 || cnt_type'(child_rdata) >= nc_ff) begin
               state_in = actb_pkg::B_NXT;
            end else begin
               state_in = actb_pkg::B_F0;
            end
         end
         actb_pkg::B_F0: begin
            f_in     = fail_rdata;
            guard_in = '0;
            state_in = actb_pkg::B_WCHK;
         end
         actb_pkg::B_WCHK: begin
            child_raddr = {f_ff, i_ff};
            if (f_ff != '0 && cnt_type'(f_ff) < nc_ff) begin
               state_in = actb_pkg::B_WRD;
            end else begin
               state_in = actb_pkg::B_FSON;
            end
         end
         actb_pkg::B_WRD: begin
            fail_raddr = f_ff;
            if (child_rdata == '0 && 32'(guard_ff) < 32'(MAX_NODES)) begin
               state_in = actb_pkg::B_WF;
            end else begin
               state_in = actb_pkg::B_FSON;
            end
         end
         actb_pkg::B_WF: begin
            f_in     = fail_rdata;
            guard_in = guard_ff + cnt_type'(1);
            state_in = actb_pkg::B_WCHK;
         end
         actb_pkg::B_FSON: begin
            child_raddr = {fsel, i_ff};
            state_in    = actb_pkg::B_WR;
         end
         actb_pkg::B_WR: begin
            fail_we      = 1'b1;
            fail_waddr   = son_ff;
            fail_wdata   = child_rdata;
            parent_we    = 1'b1;
            parent_waddr = son_ff;
            parent_wdata = cur_ff;
            if (32'(tail_ff) < 32'(MAX_NODES)) begin
               queue_we = 1'b1;
               tail_in  = tail_ff + cnt_type'(1);
            end
            state_in = actb_pkg::B_NXT;
         end
         actb_pkg::B_NXT: begin
            if (last_i) begin
               state_in = actb_pkg::B_HD;
            end else begin
               i_in     = i_ff + sym_type'(1);
               state_in = actb_pkg::B_SON;
            end
         end
         default: begin
            state_in = actb_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= actb_pkg::S_CLR;
         nc_ff        <= cnt_type'(1);
         cursor_ff    <= '0;
         row_ff       <= '0;
         k_ff         <= '0;
         ret_idle_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         guard_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         nc_ff        <= nc_in;
         cursor_ff    <= cursor_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         ret_idle_ff  <= ret_idle_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         guard_ff     <= guard_in;
      end
      op_ff    <= op_in;
      sym_ff   <= sym_in;
      idx_ff   <= idx_in;
      cur_ff   <= cur_in;
      son_ff   <= son_in;
      f_ff     <= f_in;
      res_ff   <= res_in;
      fl_ff    <= fl_in;
      par_ff   <= par_in;
      st_ff    <= st_in;
      o_res_ff <= o_res_in;
      o_fl_ff  <= o_fl_in;
      o_par_ff <= o_par_in;
      o_st_ff  <= o_st_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      nc_ff != '0 && 32'(nc_ff) <= 32'(MAX_NODES))
      else $error("node count out of range");

   a_cursor_live: assert property (@(posedge clock) disable iff (reset)
      cnt_type'(cursor_ff) < nc_ff)
      else $error("insert cursor beyond node count");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      state_ff != actb_pkg::S_IDLE && op_ff == actb_pkg::OP_BUILD |-> head_ff <= tail_ff)
      else $error("queue head passed tail");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == actb_pkg::S_FIN && rsp_valid_ff && !rsp_ch.ready
      |=> state_ff == actb_pkg::S_FIN)
      else $error("result overwrote a pending response");

endmodule
`default_nettype wire
